[rtl/core/itdd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdd_pkg
// Shared widths and constants for the binary to decimal digit converter.
// ----------------------------------------------------------------------------
package itdd_pkg;

  localparam int VALUE_W       = 32;  // width of the value field on the port
  localparam int CHAR_W        = 6;   // ASCII digit field
  localparam int COUNT_W       = 4;   // digit count field
  localparam int DEF_VALUE_WIDTH = 32;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

endpackage : itdd_pkg

[rtl/core/itdd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itdd_in_if / itdd_out_if
// Valid/ready channels carrying request words and digit words.
// ----------------------------------------------------------------------------
interface itdd_in_if
  import itdd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface : itdd_in_if

interface itdd_out_if
  import itdd_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  digit_char;
  logic [COUNT_W-1:0] digit_count;
  logic               is_negative;
  logic               last_digit;

  modport source (output valid, output digit_char, output digit_count,
                  output is_negative, output last_digit, input ready);
  modport sink   (input valid, input digit_char, input digit_count,
                  input is_negative, input last_digit, output ready);
endinterface : itdd_out_if

[rtl/core/int_to_decimal_digits.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_decimal_digits
// Converts one integer word to its decimal ASCII digits, most significant
// first, without leading zeros, by a bit-serial shift-and-add-3 pass.
//
//   Channel   Dir  Fields                                          Word
//   in_word   in   req_type, value                                 request
//   out_word  out  digit_char, digit_count, is_negative, last_digit one digit
//
// A request is loaded, then converted one input bit per cycle into the BCD
// shift register; leading zero digits are then trimmed, and the remaining
// digits are sent, most significant first, as out_word accepts them.
// Reset (rst_n low, synchronous) returns to idle and drops any pending digit.
// A stalled out_word holds its digit; conversion of the next request starts
// while the last digit still waits in the output register.
// ----------------------------------------------------------------------------
module int_to_decimal_digits
  import itdd_pkg::*;
#(
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  itdd_in_if.sink           in_word,
  itdd_out_if.source        out_word
);

  localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int BCD_W = 4 * NDIG;
  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam int LEN_W = $clog2(NDIG + 1);
  localparam int EXT_W = (VALUE_WIDTH > VALUE_W) ? VALUE_WIDTH : VALUE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONVERT,
    S_TRIM,
    S_EMIT
  } state_t;

  state_t                   state_r;
  logic [VALUE_WIDTH-1:0]   mag_r;
  logic [BCD_W-1:0]         bcd_r;
  logic [CNT_W-1:0]         bit_cnt_r;
  logic [LEN_W-1:0]         len_r;
  logic [LEN_W-1:0]         rem_r;
  logic                     neg_r;

  logic                     out_valid_r;
  logic [CHAR_W-1:0]        out_char_r;
  logic [COUNT_W-1:0]       out_count_r;
  logic                     out_neg_r;
  logic                     out_last_r;

  logic [EXT_W-1:0]         value_ext;
  logic [VALUE_WIDTH-1:0]   value_w;
  logic                     value_neg;
  logic [BCD_W-1:0]         bcd_adj;
  logic [3:0]               top_digit;
  logic                     emit_go;

  assign value_ext = EXT_W'(in_word.value);
  assign value_w   = value_ext[VALUE_WIDTH-1:0];
  assign value_neg = in_word.req_type & value_w[VALUE_WIDTH-1];
  assign top_digit = bcd_r[BCD_W-1 -: 4];
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || out_word.ready);

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_word.valid) begin
            mag_r     <= value_neg ? (~value_w + 1'b1) : value_w;
            neg_r     <= value_neg;
            bcd_r     <= '0;
            bit_cnt_r <= CNT_W'(VALUE_WIDTH - 1);
            state_r   <= S_CONVERT;
          end
        end
        S_CONVERT: begin
          bcd_r     <= {bcd_adj[BCD_W-2:0], mag_r[VALUE_WIDTH-1]};
          mag_r     <= {mag_r[VALUE_WIDTH-2:0], 1'b0};
          bit_cnt_r <= bit_cnt_r - 1'b1;
          if (bit_cnt_r == '0) begin
            len_r   <= LEN_W'(NDIG);
            state_r <= S_TRIM;
          end
        end
        S_TRIM: begin
          if (top_digit == 4'd0 && len_r != LEN_W'(1)) begin
            bcd_r <= {bcd_r[BCD_W-5:0], 4'd0};
            len_r <= len_r - 1'b1;
          end else begin
            rem_r   <= len_r;
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_char_r  <= ASCII_ZERO + {2'b00, top_digit};
            out_count_r <= COUNT_W'(len_r);
            out_neg_r   <= neg_r;
            out_last_r  <= (rem_r == LEN_W'(1));
            bcd_r       <= {bcd_r[BCD_W-5:0], 4'd0};
            rem_r       <= rem_r - 1'b1;
            if (rem_r == LEN_W'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_word.ready        = (state_r == S_IDLE);
  assign out_word.valid       = out_valid_r;
  assign out_word.digit_char  = out_char_r;
  assign out_word.digit_count = out_count_r;
  assign out_word.is_negative = out_neg_r;
  assign out_word.last_digit  = out_last_r;

endmodule : int_to_decimal_digits

[tb/int_to_decimal_digits_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_decimal_digits_test
// Self-checking bench for the decimal digit converter. Request words go in
// from a queue through a valid/ready driver with random gaps; each accepted
// request is expanded into its digit words by an internal digit predictor,
// and every digit word that leaves the block is compared field by field with
// the oldest predicted one. Directed corner values come first, then random
// values spread over all digit lengths and both signed and unsigned modes.
// ----------------------------------------------------------------------------
module int_to_decimal_digits_test;
  import itdd_pkg::*;

  localparam int VALUE_WIDTH  = DEF_VALUE_WIDTH;
  localparam int RANDOM_WORDS = 390;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic               req_type;
    logic [VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [COUNT_W-1:0] count;
    logic               is_neg;
    logic               is_last;
  } digit_t;

  logic clk;
  logic rst_n;

  itdd_in_if  req_if ();
  itdd_out_if dig_if ();

  int_to_decimal_digits #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (req_if),
    .out_word (dig_if)
  );

  request_t request_q[$];
  digit_t   digit_q[$];
  request_t next_req;
  int       n_accepted;
  bit       fail_seen;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit calm_window();
    return n_accepted >= 120 && n_accepted < 220;
  endfunction

  function automatic logic [63:0] pow10(int k);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < k; i++) p = p * 64'd10;
    return p;
  endfunction

  // Expand one request into the digit words it must produce.
  function automatic void predict_digits(request_t req);
    logic [63:0] mask;
    logic [63:0] v;
    logic [63:0] mag;
    logic [3:0]  dec[20];
    logic        neg;
    int          n;
    digit_t      d;
    mask = (VALUE_WIDTH >= 64) ? '1 : ((64'd1 << VALUE_WIDTH) - 64'd1);
    v    = 64'(req.value) & mask;
    neg  = req.req_type && v[VALUE_WIDTH-1];
    mag  = neg ? ((~v + 64'd1) & mask) : v;
    n    = 0;
    do begin
      dec[n] = 4'(mag % 64'd10);
      mag    = mag / 64'd10;
      n++;
    end while (mag != 0 && n < 20);
    for (int k = 0; k < n; k++) begin
      d.ch      = ASCII_ZERO + CHAR_W'(dec[n-1-k]);
      d.count   = COUNT_W'(n);
      d.is_neg  = neg;
      d.is_last = (k == n - 1);
      digit_q.push_back(d);
    end
  endfunction

  function automatic request_t pick_request();
    request_t r;
    int       k;
    logic [63:0] lim;
    r.req_type = 1'($urandom_range(1));
    case ($urandom_range(5))
      0, 1: r.value = $urandom;
      2: begin
        k       = $urandom_range(1, 9);
        lim     = pow10(k);
        r.value = $urandom_range(32'(lim - 64'd1));
      end
      3: begin
        k       = $urandom_range(0, 9);
        r.value = 32'(pow10(k)) - 32'($urandom_range(1));
      end
      4: r.value = $urandom_range(20);
      default: begin
        r.req_type = 1'b1;
        r.value    = -32'($urandom_range(1, 100000));
      end
    endcase
    return r;
  endfunction

  function automatic void add_request(logic t, logic [VALUE_W-1:0] v);
    request_t r;
    r.req_type = t;
    r.value    = v;
    request_q.push_back(r);
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (request_q.size() != 0 && (calm_window() || $urandom_range(99) >= 6)) begin
        next_req        = request_q.pop_front();
        req_if.valid    <= 1'b1;
        req_if.req_type <= next_req.req_type;
        req_if.value    <= next_req.value;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Digit sink ready
  always @(posedge clk) begin
    if (!rst_n) begin
      dig_if.ready <= 1'b0;
    end else begin
      dig_if.ready <= calm_window() || $urandom_range(99) >= 6;
    end
  end

  // Monitor: predict on accepted requests, check accepted digits
  always @(posedge clk) begin
    request_t acc;
    digit_t   got;
    digit_t   exp_d;
    if (rst_n && req_if.valid && req_if.ready) begin
      acc.req_type = req_if.req_type;
      acc.value    = req_if.value;
      predict_digits(acc);
      n_accepted++;
    end
    if (rst_n && dig_if.valid && dig_if.ready) begin
      got.ch      = dig_if.digit_char;
      got.count   = dig_if.digit_count;
      got.is_neg  = dig_if.is_negative;
      got.is_last = dig_if.last_digit;
      if (digit_q.size() == 0) begin
        $display("%0t: unexpected digit word, actual ch=%0d count=%0d neg=%0b last=%0b",
                 $time, got.ch, got.count, got.is_neg, got.is_last);
        fail_seen = 1'b1;
      end else begin
        exp_d = digit_q.pop_front();
        if (got.ch !== exp_d.ch) begin
          $display("%0t: digit_char expected %0d actual %0d", $time, exp_d.ch, got.ch);
          fail_seen = 1'b1;
        end
        if (got.count !== exp_d.count) begin
          $display("%0t: digit_count expected %0d actual %0d",
                   $time, exp_d.count, got.count);
          fail_seen = 1'b1;
        end
        if (got.is_neg !== exp_d.is_neg) begin
          $display("%0t: is_negative expected %0b actual %0b",
                   $time, exp_d.is_neg, got.is_neg);
          fail_seen = 1'b1;
        end
        if (got.is_last !== exp_d.is_last) begin
          $display("%0t: last_digit expected %0b actual %0b",
                   $time, exp_d.is_last, got.is_last);
          fail_seen = 1'b1;
        end
      end
    end
  end

  initial begin
    req_if.valid    = 1'b0;
    req_if.req_type = 1'b0;
    req_if.value    = '0;
    dig_if.ready    = 1'b0;
    rst_n           = 1'b0;
    n_accepted      = 0;
    fail_seen       = 1'b0;

    add_request(1'b0, 32'd0);
    add_request(1'b1, 32'd0);
    add_request(1'b0, 32'd1);
    add_request(1'b1, 32'd1);
    add_request(1'b0, 32'hFFFF_FFFF);
    add_request(1'b1, 32'hFFFF_FFFF);
    add_request(1'b1, 32'h8000_0000);
    add_request(1'b0, 32'h8000_0000);
    add_request(1'b1, 32'h7FFF_FFFF);
    add_request(1'b0, 32'h7FFF_FFFF);
    add_request(1'b0, 32'd9);
    add_request(1'b0, 32'd10);
    add_request(1'b1, 32'd99);
    add_request(1'b0, 32'd100);
    add_request(1'b0, 32'd999_999_999);
    add_request(1'b1, 32'd1_000_000_000);
    add_request(1'b1, -32'd10);
    add_request(1'b1, -32'd1_000_000_000);
    add_request(1'b0, 32'hAAAA_AAAA);
    add_request(1'b0, 32'h5555_5555);
    for (int i = 0; i < RANDOM_WORDS; i++) request_q.push_back(pick_request());

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || req_if.valid || digit_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
    if (!fail_seen && digit_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("Verification failed");
    $finish;
  end

endmodule : int_to_decimal_digits_test
